[rtl/core/dlac_pkg.sv]
`timescale 1ns / 1ps

package dlac_pkg;

  // timestamp and interval width
  localparam int TIME_BITS = 32;
  localparam int CMD_BITS  = 8;

  // operation codes
  localparam logic [1:0] OP_POLL      = 2'd0;
  localparam logic [1:0] OP_QUERY_SNS = 2'd1;
  localparam logic [1:0] OP_QUERY_CMD = 2'd2;
  localparam logic [1:0] OP_SET_CMD   = 2'd3;

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_IDLE   = 8'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOCK   = 8'd1;
  localparam logic [CMD_BITS-1:0] CMD_UNLOCK = 8'd2;
  localparam logic [CMD_BITS-1:0] CMD_HOLD   = 8'd3;

  // configuration register indexes
  localparam logic [1:0] REG_DRIVE_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_OVERRUN_HOLD  = 2'd1;

  // configuration reset values
  localparam logic [TIME_BITS-1:0] DRIVE_TIMEOUT_RST = TIME_BITS'(500000);
  localparam logic [TIME_BITS-1:0] OVERRUN_HOLD_RST  = TIME_BITS'(100000);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CMD_BITS-1:0]  cmd_t;

  // one accepted request
  typedef struct packed {
    logic [1:0] operation;
    time_t      now_us;
    logic       lock_sense;
    logic       unlock_sense;
    cmd_t       command_value;
  } item_t;

  // controller state
  typedef struct packed {
    logic  stored_lock;
    logic  stored_unlock;
    cmd_t  pending_command;
    time_t command_time;
    logic  lock_drive_level;
    logic  unlock_drive_level;
  } state_t;

  // one result
  typedef struct packed {
    logic       drive_lock;
    logic       drive_unlock;
    logic       report_valid;
    logic [1:0] report_value;
    logic       reply_valid;
    cmd_t       reply_value;
  } result_t;

  // configuration values
  typedef struct packed {
    time_t drive_timeout_us;
    time_t overrun_hold_us;
  } cfg_t;

endpackage

[rtl/core/dlac_step.sv]
`timescale 1ns / 1ps

module dlac_step (
  input  dlac_pkg::item_t   item,
  input  dlac_pkg::state_t  st,
  input  dlac_pkg::cfg_t    cfg,
  output dlac_pkg::state_t  st_next,
  output dlac_pkg::result_t res
);
  import dlac_pkg::*;

  state_t s1;
  time_t  timeout_due;
  time_t  hold_due;
  logic   timed_out;
  logic   hold_done;
  logic   sense_new;

  // deadlines wrap at the time width
  assign timeout_due = st.command_time + cfg.drive_timeout_us;
  assign hold_due    = st.command_time + cfg.overrun_hold_us;
  assign timed_out   = timeout_due < item.now_us;
  assign hold_done   = hold_due < item.now_us;

  // sensor pair changed and levels differ
  assign sense_new = ((st.stored_lock != item.lock_sense) ||
                      (st.stored_unlock != item.unlock_sense)) &&
                     (item.lock_sense != item.unlock_sense);

  always_comb begin
    s1      = st;
    st_next = st;
    res     = '0;
    case (item.operation)
      OP_POLL: begin
        // latch sensor pair
        if (sense_new) begin
          s1.stored_lock    = item.lock_sense;
          s1.stored_unlock  = item.unlock_sense;
          res.report_valid  = 1'b1;
          res.report_value  = {item.lock_sense, item.unlock_sense};
        end
        st_next = s1;
        // drive sequencing
        if (s1.pending_command != CMD_IDLE) begin
          if (timed_out) begin
            st_next.pending_command    = CMD_IDLE;
            st_next.lock_drive_level   = 1'b0;
            st_next.unlock_drive_level = 1'b0;
          end else begin
            case (s1.pending_command)
              CMD_LOCK: begin
                if (s1.stored_lock && !s1.stored_unlock) begin
                  st_next.pending_command = CMD_HOLD;
                  st_next.command_time    = item.now_us;
                end else begin
                  st_next.lock_drive_level   = 1'b1;
                  st_next.unlock_drive_level = 1'b0;
                end
              end
              CMD_UNLOCK: begin
                if (!s1.stored_lock && s1.stored_unlock) begin
                  st_next.pending_command = CMD_HOLD;
                  st_next.command_time    = item.now_us;
                end else begin
                  st_next.lock_drive_level   = 1'b0;
                  st_next.unlock_drive_level = 1'b1;
                end
              end
              CMD_HOLD: begin
                if (hold_done) begin
                  st_next.pending_command    = CMD_IDLE;
                  st_next.lock_drive_level   = 1'b0;
                  st_next.unlock_drive_level = 1'b0;
                end
              end
              default: begin
                // unknown command releases everything
                st_next.pending_command    = CMD_IDLE;
                st_next.lock_drive_level   = 1'b0;
                st_next.unlock_drive_level = 1'b0;
              end
            endcase
          end
        end
      end
      OP_QUERY_SNS: begin
        res.reply_valid = 1'b1;
        res.reply_value = {{(CMD_BITS-2){1'b0}}, st.stored_lock, st.stored_unlock};
      end
      OP_QUERY_CMD: begin
        res.reply_valid = 1'b1;
        res.reply_value = st.pending_command;
      end
      default: begin
        // set command
        st_next.command_time    = item.now_us;
        st_next.pending_command = item.command_value;
        res.reply_valid         = 1'b1;
        res.reply_value         = item.command_value;
      end
    endcase
    res.drive_lock   = st_next.lock_drive_level;
    res.drive_unlock = st_next.unlock_drive_level;
  end

endmodule

[rtl/core/dlac_out_reg.sv]
`timescale 1ns / 1ps

module dlac_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dlac_pkg::result_t res_in,
  input  logic              take,
  output logic              full,
  output dlac_pkg::result_t res_out
);
  import dlac_pkg::*;

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

[rtl/core/door_lock_actuator_control.sv]
`timescale 1ns / 1ps
// channel  signals                        direction  moves
// in       in_valid / in_ready, fields    input      one request per item
// out      out_valid / out_ready, fields  output     one result per request
// cfg      cfg_valid / cfg_ready, index   input      one register write
//
// one request per cycle sustained while out_ready stays high; each request passes from
// acceptance to its result through the input register and then the result register
// the state update and result come from a single compare and add path per request
// rst is synchronous: clears state, flags and restores register defaults
// a stalled result register holds the request in the input register; in_ready
// stays high while the input register is empty or moving forward

module door_lock_actuator_control (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  dlac_pkg::time_t          now_us,
  input  logic                     lock_sense,
  input  logic                     unlock_sense,
  input  dlac_pkg::cmd_t           command_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     drive_lock,
  output logic                     drive_unlock,
  output logic                     report_valid,
  output logic [1:0]               report_value,
  output logic                     reply_valid,
  output dlac_pkg::cmd_t           reply_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  dlac_pkg::time_t          cfg_data
);
  import dlac_pkg::*;

  logic    in_full;
  item_t   item;
  logic    advance;
  state_t  st;
  state_t  st_next;
  cfg_t    cfg;
  result_t res;
  result_t res_q;

  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{operation, now_us, lock_sense, unlock_sense, command_value};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_timeout_us <= DRIVE_TIMEOUT_RST;
      cfg.overrun_hold_us  <= OVERRUN_HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DRIVE_TIMEOUT: cfg.drive_timeout_us <= cfg_data;
        REG_OVERRUN_HOLD:  cfg.overrun_hold_us  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  dlac_step u_step (
    .item    (item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  dlac_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (advance),
    .res_in  (res),
    .take    (out_ready),
    .full    (out_valid),
    .res_out (res_q)
  );

  assign drive_lock   = res_q.drive_lock;
  assign drive_unlock = res_q.drive_unlock;
  assign report_valid = res_q.report_valid;
  assign report_value = res_q.report_value;
  assign reply_valid  = res_q.reply_valid;
  assign reply_value  = res_q.reply_value;

  // never drive both directions
  a_drive_excl: assert property (@(posedge clk) disable iff (rst)
    !(st.lock_drive_level && st.unlock_drive_level))
    else $error("both drives on");

  // a result carries a report or a reply, not both
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(report_valid && reply_valid))
    else $error("report and reply together");

  // a stalled result blocks the input register
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && out_valid && !out_ready) |=> in_full)
    else $error("request lost under stall");

  // state only moves when a request advances
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(st))
    else $error("state changed without request");

endmodule

[tb/door_lock_actuator_control_tb.sv]
`timescale 1ns / 1ps

module door_lock_actuator_control_tb;

  import dlac_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] operation;
  time_t      now_us;
  logic       lock_sense;
  logic       unlock_sense;
  cmd_t       command_value;
  logic       out_valid;
  logic       out_ready;
  logic       drive_lock;
  logic       drive_unlock;
  logic       report_valid;
  logic [1:0] report_value;
  logic       reply_valid;
  cmd_t       reply_value;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  time_t      cfg_data;

  door_lock_actuator_control u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .now_us        (now_us),
    .lock_sense    (lock_sense),
    .unlock_sense  (unlock_sense),
    .command_value (command_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_lock    (drive_lock),
    .drive_unlock  (drive_unlock),
    .report_valid  (report_valid),
    .report_value  (report_value),
    .reply_valid   (reply_valid),
    .reply_value   (reply_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock, 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted controller state and register copies
  logic    exp_sns_lock;
  logic    exp_sns_unlock;
  cmd_t    exp_cmd;
  time_t   exp_cmd_start;
  logic    exp_drv_lock;
  logic    exp_drv_unlock;
  time_t   exp_timeout;
  time_t   exp_hold;

  result_t expected_results[$];

  // typed expectation for the directed rows
  bit      row_fixed;
  result_t row_want;

  int      err_count;
  int      sent_count;
  int      checked_count;
  int      report_count;
  int      drive_on_count;
  int      cycle_count;
  time_t   clock_now;

  // receiver stall pattern
  int      stall_mode;
  int      stall_left;

  function automatic result_t mk_result(logic dl, logic du, logic rv, logic [1:0] rval,
                                        logic pv, cmd_t pval);
    result_t r;
    r.drive_lock   = dl;
    r.drive_unlock = du;
    r.report_valid = rv;
    r.report_value = rval;
    r.reply_valid  = pv;
    r.reply_value  = pval;
    return r;
  endfunction

  // deadline passed once start plus span (wrapping) is strictly below now
  function automatic bit window_expired(time_t span, time_t now);
    time_t due;
    due = exp_cmd_start + span;
    return due < now;
  endfunction

  function automatic void drop_drives();
    exp_cmd        = CMD_IDLE;
    exp_drv_lock   = 1'b0;
    exp_drv_unlock = 1'b0;
  endfunction

  // work out one result and advance the predicted state
  function automatic result_t predict_actuator(item_t rq);
    result_t r;
    r = '0;
    case (rq.operation)
      OP_POLL: begin
        // latch a changed pair only when the two levels differ
        if ({exp_sns_lock, exp_sns_unlock} != {rq.lock_sense, rq.unlock_sense} &&
            rq.lock_sense != rq.unlock_sense) begin
          exp_sns_lock   = rq.lock_sense;
          exp_sns_unlock = rq.unlock_sense;
          r.report_valid = 1'b1;
          r.report_value = {rq.lock_sense, rq.unlock_sense};
        end
        // motor drive, only with a command pending
        if (exp_cmd != CMD_IDLE) begin
          if (window_expired(exp_timeout, rq.now_us)) begin
            drop_drives();
          end else begin
            case (exp_cmd)
              CMD_LOCK: begin
                if (exp_sns_lock && !exp_sns_unlock) begin
                  exp_cmd       = CMD_HOLD;
                  exp_cmd_start = rq.now_us;
                end else begin
                  exp_drv_lock   = 1'b1;
                  exp_drv_unlock = 1'b0;
                end
              end
              CMD_UNLOCK: begin
                if (!exp_sns_lock && exp_sns_unlock) begin
                  exp_cmd       = CMD_HOLD;
                  exp_cmd_start = rq.now_us;
                end else begin
                  exp_drv_lock   = 1'b0;
                  exp_drv_unlock = 1'b1;
                end
              end
              CMD_HOLD: begin
                if (window_expired(exp_hold, rq.now_us)) drop_drives();
              end
              default: begin
                drop_drives();
              end
            endcase
          end
        end
      end
      OP_QUERY_SNS: begin
        r.reply_valid = 1'b1;
        r.reply_value = cmd_t'({exp_sns_lock, exp_sns_unlock});
      end
      OP_QUERY_CMD: begin
        r.reply_valid = 1'b1;
        r.reply_value = exp_cmd;
      end
      OP_SET_CMD: begin
        exp_cmd_start = rq.now_us;
        exp_cmd       = rq.command_value;
        r.reply_valid = 1'b1;
        r.reply_value = rq.command_value;
      end
    endcase
    r.drive_lock   = exp_drv_lock;
    r.drive_unlock = exp_drv_unlock;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // predicted state and registers out of reset
  initial begin
    exp_sns_lock   = 1'b0;
    exp_sns_unlock = 1'b0;
    exp_cmd        = CMD_IDLE;
    exp_cmd_start  = '0;
    exp_drv_lock   = 1'b0;
    exp_drv_unlock = 1'b0;
    exp_timeout    = DRIVE_TIMEOUT_RST;
    exp_hold       = OVERRUN_HOLD_RST;
    err_count      = 0;
    checked_count  = 0;
    report_count   = 0;
    drive_on_count = 0;
  end

  // monitor: register writes, accepted requests, returned results
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DRIVE_TIMEOUT: exp_timeout = cfg_data;
          REG_OVERRUN_HOLD:  exp_hold    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        item_t rq;
        rq.operation     = operation;
        rq.now_us        = now_us;
        rq.lock_sense    = lock_sense;
        rq.unlock_sense  = unlock_sense;
        rq.command_value = command_value;
        want = predict_actuator(rq);
        if (row_fixed) want = row_want;
        expected_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = mk_result(drive_lock, drive_unlock, report_valid, report_value,
                        reply_valid, reply_value);
        if (expected_results.size() == 0) begin
          err_count++;
          $error("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("drive_lock", 32'(want.drive_lock), 32'(got.drive_lock));
          check_field("drive_unlock", 32'(want.drive_unlock), 32'(got.drive_unlock));
          check_field("report_valid", 32'(want.report_valid), 32'(got.report_valid));
          check_field("report_value", 32'(want.report_value), 32'(got.report_value));
          check_field("reply_valid", 32'(want.reply_valid), 32'(got.reply_valid));
          check_field("reply_value", 32'(want.reply_value), 32'(got.reply_value));
          checked_count++;
          if (got.report_valid) report_count++;
          if (got.drive_lock || got.drive_unlock) drive_on_count++;
        end
      end
    end
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: stretches of full rate, light and heavy stalling
  initial begin
    out_ready  = 1'b0;
    stall_mode = 0;
    stall_left = 0;
  end
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 40);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready = 1'b1;
      1:       out_ready = 1'($urandom_range(0, 1));
      2:       out_ready = ($urandom_range(0, 3) == 0);
      default: out_ready = ($urandom_range(0, 7) != 0);
    endcase
  end

  // one request, held until accepted
  task automatic push_request(input item_t rq, input bit fixed, input result_t want);
    @(negedge clk);
    in_valid      = 1'b1;
    operation     = rq.operation;
    now_us        = rq.now_us;
    lock_sense    = rq.lock_sense;
    unlock_sense  = rq.unlock_sense;
    command_value = rq.command_value;
    row_fixed     = fixed;
    row_want      = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    in_valid  = 1'b0;
    row_fixed = 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    idle_cycles(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input time_t data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // directed rows
  item_t   dir_items[$];
  bit      dir_fixed[$];
  result_t dir_want[$];

  task automatic add_row(input logic [1:0] op, input time_t t, input logic l, input logic u,
                         input cmd_t c, input bit fixed, input result_t want);
    item_t rq;
    rq.operation     = op;
    rq.now_us        = t;
    rq.lock_sense    = l;
    rq.unlock_sense  = u;
    rq.command_value = c;
    dir_items.push_back(rq);
    dir_fixed.push_back(fixed);
    dir_want.push_back(want);
  endtask

  task automatic run_directed();
    result_t none;
    none = '0;
    // fresh out of reset
    add_row(OP_QUERY_SNS, 32'd0, 1'b0, 1'b0, 8'd0, 1'b1,
            mk_result(1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'd0));
    add_row(OP_QUERY_CMD, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 1'b1,
            mk_result(1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'd0));
    // equal sensor levels are never latched
    add_row(OP_POLL, 32'd0, 1'b0, 1'b0, 8'd0, 1'b1,
            mk_result(1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 8'd0));
    add_row(OP_POLL, 32'd5, 1'b1, 1'b1, 8'd0, 1'b1,
            mk_result(1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 8'd0));
    add_row(OP_POLL, 32'd10, 1'b0, 1'b1, 8'd0, 1'b1,
            mk_result(1'b0, 1'b0, 1'b1, 2'd1, 1'b0, 8'd0));
    // lock, drive right up to the timeout edge, then time out
    add_row(OP_SET_CMD, 32'd100, 1'b0, 1'b0, CMD_LOCK, 1'b1,
            mk_result(1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_LOCK));
    add_row(OP_POLL, 32'd200, 1'b0, 1'b1, 8'd0, 1'b0, none);
    add_row(OP_POLL, 32'd500100, 1'b0, 1'b1, 8'd0, 1'b0, none);
    add_row(OP_POLL, 32'd500101, 1'b0, 1'b1, 8'd0, 1'b0, none);
    // lock reached, hold to the overrun edge and release
    add_row(OP_SET_CMD, 32'd1000, 1'b0, 1'b0, CMD_LOCK, 1'b0, none);
    add_row(OP_POLL, 32'd1001, 1'b1, 1'b0, 8'd0, 1'b0, none);
    add_row(OP_QUERY_CMD, 32'd1001, 1'b0, 1'b0, 8'd0, 1'b0, none);
    add_row(OP_POLL, 32'd101001, 1'b1, 1'b0, 8'd0, 1'b0, none);
    add_row(OP_POLL, 32'd101002, 1'b1, 1'b0, 8'd0, 1'b0, none);
    // deadline wrapping past the top of the timestamp range
    add_row(OP_SET_CMD, 32'hFFFF_FFF0, 1'b0, 1'b0, CMD_UNLOCK, 1'b0, none);
    add_row(OP_POLL, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'd0, 1'b0, none);
    // unlock reached, then command cleared with the drive still held
    add_row(OP_SET_CMD, 32'd2000, 1'b0, 1'b0, CMD_UNLOCK, 1'b0, none);
    add_row(OP_POLL, 32'd2001, 1'b1, 1'b0, 8'd0, 1'b0, none);
    add_row(OP_POLL, 32'd2002, 1'b0, 1'b1, 8'd0, 1'b0, none);
    add_row(OP_SET_CMD, 32'd3000, 1'b0, 1'b0, CMD_IDLE, 1'b0, none);
    add_row(OP_POLL, 32'd9000000, 1'b1, 1'b0, 8'd0, 1'b0, none);
    // hold set directly
    add_row(OP_SET_CMD, 32'd4000, 1'b0, 1'b0, CMD_HOLD, 1'b0, none);
    add_row(OP_POLL, 32'd104001, 1'b1, 1'b0, 8'd0, 1'b0, none);
    // unknown command is cleared by the next poll
    add_row(OP_SET_CMD, 32'd5000, 1'b0, 1'b0, 8'hA5, 1'b0, none);
    add_row(OP_POLL, 32'd5001, 1'b1, 1'b0, 8'd0, 1'b0, none);
    add_row(OP_QUERY_CMD, 32'd5002, 1'b0, 1'b0, 8'd0, 1'b1,
            mk_result(1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_IDLE));
    foreach (dir_items[i]) push_request(dir_items[i], dir_fixed[i], dir_want[i]);
  endtask

  // random requests around a simple motor: a set command starts travel,
  // later polls see the target sensor; some noise and stray requests
  task automatic random_phase(input int count, input int step_max);
    item_t      rq;
    result_t    none;
    int         burst;
    int         pick;
    logic [1:0] target;
    bit         arrived;
    none    = '0;
    burst   = $urandom_range(1, 40);
    target  = $urandom_range(0, 1) ? 2'b10 : 2'b01;
    arrived = 1'b0;
    for (int n = 0; n < count; n++) begin
      // sender bursts and gaps, one full stop mid phase
      if (n == count / 2) begin
        drain();
      end else if (burst == 0) begin
        idle_cycles($urandom_range(1, 8));
        burst = $urandom_range(1, 40);
      end
      burst--;
      // timestamp mostly creeps forward, sometimes jumps anywhere
      pick = $urandom_range(0, 99);
      if (pick < 2) clock_now = $urandom;
      else if (pick < 3) clock_now = clock_now - $urandom_range(0, step_max);
      else clock_now = clock_now + $urandom_range(0, step_max);
      rq.now_us        = clock_now;
      rq.command_value = cmd_t'($urandom_range(0, 255));
      rq.lock_sense    = 1'($urandom_range(0, 1));
      rq.unlock_sense  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        rq.operation = OP_POLL;
        if ($urandom_range(0, 99) >= 12) begin
          if (!arrived && $urandom_range(0, 4) == 0) arrived = 1'b1;
          {rq.lock_sense, rq.unlock_sense} = arrived ? target : 2'b00;
        end
      end else if (pick < 76) begin
        rq.operation = OP_SET_CMD;
        pick = $urandom_range(0, 99);
        if (pick < 40) rq.command_value = CMD_LOCK;
        else if (pick < 80) rq.command_value = CMD_UNLOCK;
        else if (pick < 86) rq.command_value = CMD_IDLE;
        else if (pick < 92) rq.command_value = CMD_HOLD;
        if (rq.command_value == CMD_LOCK || rq.command_value == CMD_UNLOCK) begin
          target  = (rq.command_value == CMD_LOCK) ? 2'b10 : 2'b01;
          arrived = 1'b0;
        end
      end else if (pick < 88) begin
        rq.operation = OP_QUERY_SNS;
      end else begin
        rq.operation = OP_QUERY_CMD;
      end
      push_request(rq, 1'b0, none);
    end
    drain();
  endtask

  // stimulus
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    operation     = OP_POLL;
    now_us        = '0;
    lock_sense    = 1'b0;
    unlock_sense  = 1'b0;
    command_value = CMD_IDLE;
    cfg_valid     = 1'b0;
    cfg_index     = REG_DRIVE_TIMEOUT;
    cfg_data      = '0;
    row_fixed     = 1'b0;
    row_want      = '0;
    sent_count    = 0;
    clock_now     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    drain();

    // short windows so timeouts and holds come round often
    write_reg(REG_DRIVE_TIMEOUT, 32'd300);
    write_reg(REG_OVERRUN_HOLD, 32'd60);
    random_phase(350, 20);

    // zero windows
    write_reg(REG_DRIVE_TIMEOUT, 32'd0);
    write_reg(REG_OVERRUN_HOLD, 32'd0);
    random_phase(250, 3);

    // largest windows, deadline wraps to just below the start
    write_reg(REG_DRIVE_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_OVERRUN_HOLD, 32'hFFFF_FFFF);
    random_phase(250, 50);

    // reset values, timestamps running over the top of the range
    write_reg(REG_DRIVE_TIMEOUT, DRIVE_TIMEOUT_RST);
    write_reg(REG_OVERRUN_HOLD, OVERRUN_HOLD_RST);
    clock_now = 32'hFFF0_0000;
    random_phase(250, 40000);

    // random moderate windows
    write_reg(REG_DRIVE_TIMEOUT, $urandom_range(50, 2000));
    write_reg(REG_OVERRUN_HOLD, $urandom_range(1, 500));
    random_phase(250, 100);

    $display("%0d requests sent over six register settings, %0d results checked",
             sent_count, checked_count);
    $display("%0d sensor reports seen, %0d results with a drive active",
             report_count, drive_on_count);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      if (expected_results.size() != 0)
        $error("%0d results never arrived", expected_results.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
